// ===== rtl/ctic_pkg.sv =====
// ----------------------------------------------------------------------------
// ctic_pkg - shared types and constants for the color temperature unit
// transaction payloads, status codes and fixed coefficients
// ----------------------------------------------------------------------------
package ctic_pkg;

	// status codes in the order they are checked
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_CLEAR_ZERO = 2'd1,
		ST_SATURATED  = 2'd2,
		ST_RED_ZERO   = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] red_count;
		logic [15:0] green_count;
		logic [15:0] blue_count;
		logic [15:0] clear_count;
	} sample_t;

	typedef struct packed {
		logic [15:0] kelvin;
		status_t     status;
	} result_t;

	localparam int CNT_W          = 16;
	localparam int SUM_W          = 18;
	localparam int NUM_W          = 28;
	localparam int DIV_BITS       = NUM_W;
	localparam int K_SCALE        = 3810;
	localparam int K_OFFSET       = 1391;
	localparam int SAT_MAX        = 65535;
	localparam int SAT_CYCLES_MAX = 63;
	localparam int ATIME_RESET    = 255;

endpackage

// ===== rtl/color_temp_ir_compensated_unit.sv =====
// ----------------------------------------------------------------------------
// color_temp_ir_compensated_unit - dn40 color temperature with ir removal
// pipelined estimate of color temperature from red, green, blue, clear counts
// ----------------------------------------------------------------------------
// One sample transaction enters per clock and one result transaction leaves
// per clock, sustained while the result channel is not stalled; every sample
// gives exactly one result, in order. The pipeline is made of four front
// stages (saturation and clear checks with the channel sum, ir estimate, ir
// removal, scaling multiply), a 28-stage restoring divider that resolves one
// quotient bit per stage, and the output stage that adds the offset. The
// divider makes up most of the pipeline. A two-entry output (the last stage
// plus a skid register) lets the pipeline move one more step while a result
// waits; sample_stall then comes from a register. The integration time
// register is written through its own port, which is always ready, and must
// only be changed while no sample is in flight.
module color_temp_ir_compensated_unit
	import ctic_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	// integration time register write
	input  logic          atime_valid,
	output logic          atime_ready,
	input  logic [7:0]    atime_data,
	// sample channel
	input  logic          sample_valid,
	output logic          sample_stall,
	input  sample_t       sample,
	// result channel
	output logic          result_valid,
	input  logic          result_stall,
	output result_t       result
);

	// stage map: 0..3 front, 4..4+DIV_BITS-1 divider, last one output
	localparam int DIV_FIRST = 4;
	localparam int NS        = DIV_FIRST + DIV_BITS + 1;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	logic [7:0] atime_q;

	assign atime_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atime_q <= 8'(ATIME_RESET);
		end else if (atime_valid && atime_ready) begin
			atime_q <= atime_data;
		end
	end

	// saturation level: full scale when cycles exceeds 63, else 768 * cycles
	logic [8:0]       cycles;
	logic [CNT_W-1:0] sat_lvl;

	always_comb begin
		cycles = 9'd256 - {1'b0, atime_q};
		if (cycles > 9'(SAT_CYCLES_MAX)) begin
			sat_lvl = CNT_W'(SAT_MAX);
		end else begin
			sat_lvl = {cycles[5:0], 10'b0} - {2'b0, cycles[5:0], 8'b0};
		end
	end

	// ------------------------------------------------------------------
	// flow control: the whole pipeline moves unless the skid is full
	// ------------------------------------------------------------------
	logic          en;
	logic [NS-1:0] vld_s;
	logic          skid_full_q;
	result_t       skid_q;
	result_t       result_s;

	assign en           = !skid_full_q;
	assign sample_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			skid_full_q <= 1'b0;
		end else begin
			if (en) begin
				vld_s <= {vld_s[NS-2:0], sample_valid};
				// last stage still waiting: park it in the skid
				if (vld_s[NS-1] && result_stall) begin
					skid_full_q <= 1'b1;
				end
			end else if (!result_stall) begin
				skid_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s[NS-1] && result_stall) begin
			skid_q <= result_s;
		end
	end

	assign result_valid = skid_full_q || vld_s[NS-1];
	assign result       = skid_full_q ? skid_q : result_s;

	// ------------------------------------------------------------------
	// stage 1: clear checks and channel sum
	// ------------------------------------------------------------------
	status_t          st_in;
	status_t          st_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [CNT_W-1:0] clr_s1, red_s1, blu_s1;

	always_comb begin
		priority if (sample.clear_count == '0) begin
			st_in = ST_CLEAR_ZERO;
		end else if (sample.clear_count >= sat_lvl) begin
			st_in = ST_SATURATED;
		end else begin
			st_in = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1  <= st_in;
			sum_s1 <= SUM_W'(sample.red_count) + SUM_W'(sample.green_count)
				+ SUM_W'(sample.blue_count);
			clr_s1 <= sample.clear_count;
			red_s1 <= sample.red_count;
			blu_s1 <= sample.blue_count;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: ir estimate, half the excess of the sum over clear
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] excess;
	logic [CNT_W-1:0] ir_s2, red_s2, blu_s2;
	status_t          st_s2;

	assign excess = sum_s1 - SUM_W'(clr_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ir_s2  <= (sum_s1 > SUM_W'(clr_s1)) ? excess[CNT_W:1] : '0;
			red_s2 <= red_s1;
			blu_s2 <= blu_s1;
			st_s2  <= st_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: ir removal with 16-bit wrap
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] red_adj, r2_s3, b2_s3;
	status_t          st_s3;

	assign red_adj = red_s2 - ir_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s3 <= red_adj;
			b2_s3 <= blu_s2 - ir_s2;
			st_s3 <= (st_s2 == ST_OK && red_adj == '0) ? ST_RED_ZERO : st_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: scale blue
	// ------------------------------------------------------------------
	logic [NUM_W-1:0] num_s4;
	logic [CNT_W-1:0] den_s4;
	status_t          st_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= NUM_W'(b2_s3) * NUM_W'(K_SCALE);
			den_s4 <= r2_s3;
			st_s4  <= st_s3;
		end
	end

	// ------------------------------------------------------------------
	// divider: restoring, one quotient bit per stage, msb first
	// the numerator shifts out the top while quotient bits shift in
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] div_rem_s [DIV_BITS];
	logic [NUM_W-1:0] div_nq_s  [DIV_BITS];
	logic [CNT_W-1:0] div_den_s [DIV_BITS];
	status_t          div_st_s  [DIV_BITS];

	for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
		logic [CNT_W-1:0] rem_in, den_in;
		logic [NUM_W-1:0] nq_in;
		status_t          st_prev;
		logic [CNT_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign nq_in   = num_s4;
			assign den_in  = den_s4;
			assign st_prev = st_s4;
		end else begin : g_next
			assign rem_in  = div_rem_s[i-1];
			assign nq_in   = div_nq_s[i-1];
			assign den_in  = div_den_s[i-1];
			assign st_prev = div_st_s[i-1];
		end

		assign trial = {rem_in, nq_in[NUM_W-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[i] <= ge ? CNT_W'(trial - {1'b0, den_in}) : trial[CNT_W-1:0];
				div_nq_s[i]  <= {nq_in[NUM_W-2:0], ge};
				div_den_s[i] <= den_in;
				div_st_s[i]  <= st_prev;
			end
		end
	end

	// ------------------------------------------------------------------
	// output stage: add offset, zero on any special case
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			result_s.status <= div_st_s[DIV_BITS-1];
			result_s.kelvin <= (div_st_s[DIV_BITS-1] == ST_OK)
				? div_nq_s[DIV_BITS-1][CNT_W-1:0] + CNT_W'(K_OFFSET) : '0;
		end
	end

endmodule
